// File: hdl/pfsr_pkg.sv
// Shared types and constants for the packet framer with sum check and resync.
// Used by pfsr_ctrl, pfsr_dp and packet_framer_sum_resync; no dependencies.
package pfsr_pkg;

  localparam int DATA_W           = 8;   // byte width
  localparam int IDX_W            = 6;   // byte_index port width
  localparam int PACKET_BYTES_DEF = 16;  // default packet length

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index = paddr[2]
  localparam logic REG_START_BYTE = 1'b0;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_in;        // store rx byte at fill position
    logic fill_inc;
    logic fill_clr;
    logic fill_load_k;  // fill = PACKET_BYTES - k after resync shift
    logic ptr_clr;
    logic ptr_inc;
    logic ptr_load_k;
    logic rd_en;        // read store at ptr
    logic scan_clr;     // clear sum and start search
    logic scan;         // accumulate / search on returning read data
    logic out_load;     // capture read data into output register
    logic wptr_clr;
    logic shift;        // write returning read data at wptr
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic rx_is_start;
    logic fill_last;
    logic ptr_last;
    logic out_last;
    logic sum_ok;
    logic found;
  } status_t;

endpackage

// File: hdl/pfsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pfsr_dp.sv
// Datapath: packet store, fill and read pointers, checksum accumulator,
// start-byte search and output register. Depends on pfsr_pkg and pfsr_ram.
module pfsr_dp #(
  parameter int PACKET_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfsr_pkg::cmd_t              cmd_i,
  output pfsr_pkg::status_t           st_o,
  input  logic [pfsr_pkg::DATA_W-1:0] start_byte_i,
  input  logic [pfsr_pkg::DATA_W-1:0] rx_byte_i,
  output logic [pfsr_pkg::DATA_W-1:0] packet_byte_o,
  output logic [pfsr_pkg::IDX_W-1:0]  byte_index_o,
  output logic [pfsr_pkg::DATA_W-1:0] sum_computed_o,
  output logic [pfsr_pkg::DATA_W-1:0] sum_received_o,
  output logic                        sum_ok_o,
  output logic                        last_o
);
  import pfsr_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [AW-1:0] LAST_POS = AW'(PACKET_BYTES - 1);

  logic [AW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     raddr_q;
  logic              rvalid_q;
  logic [DATA_W-1:0] sum_q, sumr_q;
  logic              found_q;
  logic [AW-1:0]     k_q;
  logic [DATA_W-1:0] out_byte_q;
  logic [AW-1:0]     out_idx_q;
  logic              out_last_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              shift_wr;
  logic              scan_hit;

  assign shift_wr  = cmd_i.shift & rvalid_q;
  assign ram_we    = cmd_i.wr_in | shift_wr;
  assign ram_waddr = cmd_i.wr_in ? fill_q : wptr_q;
  assign ram_wdata = cmd_i.wr_in ? rx_byte_i : ram_rdata;

  pfsr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(PACKET_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.fill_load_k) begin
      fill_d = AW'(PACKET_BYTES) - k_q;  // modulo 2^AW, exact for k >= 1
    end else if (cmd_i.fill_inc) begin
      fill_d = fill_q + 1'b1;
    end

    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_load_k) begin
      ptr_d = k_q;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + 1'b1;
    end

    wptr_d = wptr_q;
    if (cmd_i.wptr_clr) begin
      wptr_d = '0;
    end else if (shift_wr) begin
      wptr_d = wptr_q + 1'b1;
    end
  end

  // first start byte at position one or later
  assign scan_hit = cmd_i.scan & rvalid_q & ~found_q & (raddr_q != '0)
                    & (ram_rdata == start_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      ptr_q    <= '0;
      wptr_q   <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      ptr_q    <= ptr_d;
      wptr_q   <= wptr_d;
      rvalid_q <= cmd_i.rd_en;
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (scan_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      raddr_q <= ptr_q;
    end
    if (scan_hit) begin
      k_q <= raddr_q;
    end
    if (cmd_i.scan_clr) begin
      sum_q <= '0;
    end else if (cmd_i.scan && rvalid_q) begin
      if (raddr_q == LAST_POS) begin
        sumr_q <= ram_rdata;
      end else begin
        sum_q <= sum_q + ram_rdata;
      end
    end
    if (cmd_i.out_load) begin
      out_byte_q <= ram_rdata;
      out_idx_q  <= raddr_q;
      out_last_q <= (raddr_q == LAST_POS);
    end
  end

  assign st_o.rx_is_start = (rx_byte_i == start_byte_i);
  assign st_o.fill_last   = (fill_q == LAST_POS);
  assign st_o.ptr_last    = (ptr_q == LAST_POS);
  assign st_o.out_last    = out_last_q;
  assign st_o.sum_ok      = (sum_q == sumr_q);
  assign st_o.found       = found_q;

  assign packet_byte_o  = out_byte_q;
  assign byte_index_o   = IDX_W'(out_idx_q);
  assign sum_computed_o = sum_q;
  assign sum_received_o = sumr_q;
  assign sum_ok_o       = (sum_q == sumr_q);
  assign last_o         = out_last_q;

endmodule

// File: hdl/pfsr_ctrl.sv
// Controller FSM: hunt, collect, checksum walk, output run, resync shift.
// Drives pfsr_dp through cmd_t, reads status_t. Depends on pfsr_pkg.
module pfsr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfsr_pkg::status_t   st_i,
  output pfsr_pkg::cmd_t      cmd_o
);
  import pfsr_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT,
    S_COLLECT,
    S_SUM,
    S_SUM_END,
    S_EMIT_RD,
    S_EMIT_LD,
    S_HOLD,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   shift_end_q, shift_end_d;
  logic   in_fire, out_fire;
  cmd_t   cmd;

  assign in_fire  = in_valid_i & in_ready_q;
  assign out_fire = out_valid_q & out_ready_i;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    shift_end_d = 1'b0;
    case (state_q)
      S_HUNT: begin
        if (in_fire && st_i.rx_is_start) begin
          cmd.wr_in    = 1'b1;
          cmd.fill_inc = 1'b1;
          state_d      = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (in_fire) begin
          cmd.wr_in = 1'b1;
          if (st_i.fill_last) begin
            cmd.scan_clr = 1'b1;
            cmd.ptr_clr  = 1'b1;
            in_ready_d   = 1'b0;
            state_d      = S_SUM;
          end else begin
            cmd.fill_inc = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        if (st_i.ptr_last) begin
          state_d = S_SUM_END;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SUM_END: begin
        cmd.scan    = 1'b1;
        cmd.ptr_clr = 1'b1;
        state_d     = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.out_load = 1'b1;
        cmd.ptr_inc  = ~st_i.ptr_last;
        out_valid_d  = 1'b1;
        state_d      = S_HOLD;
      end
      S_HOLD: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (!st_i.out_last) begin
            cmd.rd_en = 1'b1;
            state_d   = S_EMIT_LD;
          end else if (st_i.sum_ok || !st_i.found) begin
            cmd.fill_clr = 1'b1;
            in_ready_d   = 1'b1;
            state_d      = S_HUNT;
          end else begin
            cmd.ptr_load_k = 1'b1;
            cmd.wptr_clr   = 1'b1;
            state_d        = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // read at ptr, write the returning beat in the following cycle at wptr
        cmd.shift = 1'b1;
        if (shift_end_q) begin
          cmd.fill_load_k = 1'b1;
          in_ready_d      = 1'b1;
          state_d         = S_COLLECT;
        end else begin
          cmd.rd_en = 1'b1;
          if (st_i.ptr_last) begin
            shift_end_d = 1'b1;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      default: begin
        cmd.fill_clr = 1'b1;
        in_ready_d   = 1'b1;
        out_valid_d  = 1'b0;
        state_d      = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HUNT;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      shift_end_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
      shift_end_q <= shift_end_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("input ready while a result beat is pending");

  a_ready_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q == (state_q == S_HUNT || state_q == S_COLLECT))
    else $error("input ready out of step with state");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT_LD))
    else $error("result beat raised without a store read");

  a_shift_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (st_i.found && !st_i.sum_ok))
    else $error("resync shift without mismatch and start byte");

endmodule

// File: hdl/packet_framer_sum_resync.sv
// Fixed-length packet framer with an 8-bit additive checksum and resync.
// Received bytes enter one beat at a time on in_valid_i/in_ready_o. While
// hunting, bytes other than start_byte are dropped; a start byte opens a
// packet that collects PACKET_BYTES beats. A byte that does not complete a
// packet is taken, and in_ready_o stays high.
// The completing byte starts a sum walk over the packet store (one store
// read per cycle, N = PACKET_BYTES); after S_SUM_END the first result beat
// is read in S_EMIT_RD and loaded in S_EMIT_LD, and the run of N result
// beats follows on out_valid_o/out_ready_i. Reads go through the store's
// registered read port, and the next beat is read only once the current
// one is taken. After a checksum mismatch with a start byte found at
// position k >= 1, the bytes from k are copied to the front and collection
// resumes. in_ready_o is low during the walk, the run and the copy. A
// stalled receiver holds the current result beat; nothing is dropped.
// Reset (rst_ni low) returns to hunting with start_byte = 0; no store clear.
// start_byte is register 0 on the APB port (byte address 0).
module packet_framer_sum_resync #(
  parameter int PACKET_BYTES = pfsr_pkg::PACKET_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pfsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pfsr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pfsr_pkg::DATA_W-1:0]         rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pfsr_pkg::DATA_W-1:0]         packet_byte_o,
  output logic [pfsr_pkg::IDX_W-1:0]          byte_index_o,
  output logic [pfsr_pkg::DATA_W-1:0]         sum_computed_o,
  output logic [pfsr_pkg::DATA_W-1:0]         sum_received_o,
  output logic                                sum_ok_o,
  output logic                                last_o
);
  import pfsr_pkg::*;

  logic [DATA_W-1:0] start_byte_q;
  logic              reg_sel;
  cmd_t              cmd;
  status_t           st;

  assign reg_sel = (paddr[2] == REG_START_BYTE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(start_byte_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      start_byte_q <= pwdata[DATA_W-1:0];
    end
  end

  pfsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pfsr_dp #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .start_byte_i  (start_byte_q),
    .rx_byte_i     (rx_byte_i),
    .packet_byte_o (packet_byte_o),
    .byte_index_o  (byte_index_o),
    .sum_computed_o(sum_computed_o),
    .sum_received_o(sum_received_o),
    .sum_ok_o      (sum_ok_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/sv/tb_packet_framer_sum_resync.sv
// Testbench for packet_framer_sum_resync: directed and random byte streams,
// an in-bench framing/checksum predictor and a beat-by-beat output scoreboard.
// Depends on pfsr_pkg and the packet_framer_sum_resync RTL.
module tb_packet_framer_sum_resync;
  import pfsr_pkg::*;

  localparam int PKT_LEN        = PACKET_BYTES_DEF;
  localparam int SETTLE_CYCLES  = 4 * PKT_LEN + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BYTES    = 150;

  localparam logic [APB_ADDR_W-1:0] START_BYTE_ADDR = {REG_START_BYTE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR  = {~REG_START_BYTE, 2'b00};

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] sum_c;
    logic [DATA_W-1:0] sum_r;
    logic              ok;
    logic              last;
  } pkt_beat_t;

  typedef enum logic [1:0] {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_OFF} idle_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [DATA_W-1:0]     rx_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [DATA_W-1:0]     packet_byte_o;
  logic [IDX_W-1:0]      byte_index_o;
  logic [DATA_W-1:0]     sum_computed_o;
  logic [DATA_W-1:0]     sum_received_o;
  logic                  sum_ok_o;
  logic                  last_o;

  logic [DATA_W-1:0] rx_pending[$];
  pkt_beat_t         beats_due[$];
  idle_mode_e        idle_mode    = IDLE_RX_HEAVY;
  int                n_queued     = 0;
  int                n_taken      = 0;
  int                n_errors     = 0;
  int                hold_req     = 0;
  int                hold_ack     = 0;
  int                hold_left    = 0;
  int                quiet_cycles = 0;

  // framing predictor state
  logic [DATA_W-1:0] start_cfg = '0;
  logic              hunting   = 1'b1;
  int                fill      = 0;
  logic [DATA_W-1:0] held [PKT_LEN];

  packet_framer_sum_resync #(
    .PACKET_BYTES(PKT_LEN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_byte_o  (packet_byte_o),
    .byte_index_o   (byte_index_o),
    .sum_computed_o (sum_computed_o),
    .sum_received_o (sum_received_o),
    .sum_ok_o       (sum_ok_o),
    .last_o         (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int tx_idle_pct();
    case (idle_mode)
      IDLE_RX_HEAVY: return 16;
      IDLE_TX_HEAVY: return 69;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_mode)
      IDLE_RX_HEAVY: return 69;
      IDLE_TX_HEAVY: return 16;
      default:       return 0;
    endcase
  endfunction

  // Advance the framer by one received byte; a completed packet queues its whole run.
  function automatic void frame_rx_byte(input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] sum_c;
    logic [DATA_W-1:0] sum_r;
    pkt_beat_t         beat;
    int                i;
    int                k;
    if (hunting) begin
      if (b != start_cfg) return;
      hunting = 1'b0;
      fill    = 0;
    end
    if (fill >= PKT_LEN) begin
      hunting = 1'b1;
      fill    = 0;
      return;
    end
    held[fill] = b;
    fill++;
    if (fill < PKT_LEN) return;

    sum_c = '0;
    for (i = 0; i < PKT_LEN - 1; i++) sum_c += held[i];
    sum_r = held[PKT_LEN-1];
    for (i = 0; i < PKT_LEN; i++) begin
      beat.data  = held[i];
      beat.idx   = i[IDX_W-1:0];
      beat.sum_c = sum_c;
      beat.sum_r = sum_r;
      beat.ok    = (sum_c == sum_r);
      beat.last  = (i == PKT_LEN - 1);
      beats_due.push_back(beat);
    end

    hunting = 1'b1;
    fill    = 0;
    if (sum_c != sum_r) begin
      // resync: the head byte is never a candidate
      k = 1;
      while (k < PKT_LEN && held[k] != start_cfg) k++;
      if (k < PKT_LEN) begin
        for (i = k; i < PKT_LEN; i++) held[i-k] = held[i];
        hunting = 1'b0;
        fill    = PKT_LEN - k;
      end
    end
  endfunction

  function automatic void check_field(input string fname, input int unsigned expv,
                                      input int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, expv, actv);
      n_errors++;
    end
  endfunction

  function automatic void check_beat();
    pkt_beat_t want;
    if (beats_due.size() == 0) begin
      $display("%0t: unexpected beat: expected none, actual byte 0x%0h index %0d",
               $time, packet_byte_o, byte_index_o);
      n_errors++;
      return;
    end
    want = beats_due.pop_front();
    check_field("packet_byte", want.data, packet_byte_o);
    check_field("byte_index", want.idx, byte_index_o);
    check_field("sum_computed", want.sum_c, sum_computed_o);
    check_field("sum_received", want.sum_r, sum_received_o);
    check_field("sum_ok", want.ok, sum_ok_o);
    check_field("last", want.last, last_o);
  endfunction

  // rx driver: predicts on every accepted beat, then offers the next pending byte
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_rx_byte(rx_byte_i);
      n_taken++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && rx_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_pending.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // packet monitor and receiver backpressure
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) check_beat();
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == START_BYTE_ADDR) start_cfg = data[DATA_W-1:0];
  endtask

  task automatic apb_check_start();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= START_BYTE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("start_byte readback", start_cfg, prdata[DATA_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || beats_due.size() != 0) @(posedge clk_i);
    // a resync copy may still run after the last beat
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void queue_rx(input logic [DATA_W-1:0] b);
    rx_pending.push_back(b);
    n_queued++;
  endfunction

  // body plus checksum; a nonzero skew spoils the checksum
  function automatic void queue_packet(input logic [DATA_W-1:0] body [PKT_LEN-1],
                                       input logic [DATA_W-1:0] skew);
    logic [DATA_W-1:0] chk;
    chk = skew;
    foreach (body[i]) begin
      queue_rx(body[i]);
      chk += body[i];
    end
    queue_rx(chk);
  endfunction

  // mostly framed packets with random content and stray start bytes,
  // some line noise and some cut-off packets
  function automatic void queue_traffic(input int n_bytes);
    logic [DATA_W-1:0] body [PKT_LEN-1];
    int                pushed;
    int                cut;
    pushed = 0;
    while (pushed < n_bytes) begin
      case ($urandom_range(0, 9))
        0: begin
          cut = $urandom_range(1, 3);
          repeat (cut) queue_rx($urandom_range(0, 255));
          pushed += cut;
        end
        1: begin
          cut = $urandom_range(1, PKT_LEN - 2);
          queue_rx(start_cfg);
          repeat (cut) queue_rx($urandom_range(0, 255));
          pushed += cut + 1;
        end
        default: begin
          foreach (body[i]) begin
            body[i] = (i == 0 || $urandom_range(0, 9) == 0) ? start_cfg
                                                             : $urandom_range(0, 255);
          end
          queue_packet(body, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 255));
          pushed += PKT_LEN;
        end
      endcase
    end
  endfunction

  initial begin
    logic [DATA_W-1:0] body [PKT_LEN-1];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: upper pwdata bits must be dropped, spare register ignored
    apb_write(START_BYTE_ADDR, 32'hFFFF_FFA5);
    apb_write(SPARE_REG_ADDR, 32'h0000_003C);
    apb_check_start();
    queue_rx(8'h00);
    queue_rx(8'hFF);
    // good packet with the start byte repeated as plain data
    body = '{8'hA5, 8'h00, 8'hFF, 8'hA5, 8'h01, 8'h02, 8'h04, 8'h08,
             8'h10, 8'h20, 8'h40, 8'h80, 8'h55, 8'hAA, 8'h7F};
    queue_packet(body, 8'h00);
    // bad sum, start bytes at 5 and 10 -> resync shifts, then more bytes
    body = '{8'hA5, 8'h11, 8'h22, 8'h33, 8'h44, 8'hA5, 8'h66, 8'h77,
             8'h88, 8'h99, 8'hA5, 8'hBB, 8'hCC, 8'hDD, 8'hEE};
    queue_packet(body, 8'h80);
    repeat (5) queue_rx(8'h00);
    wait_drained();

    apb_write(START_BYTE_ADDR, 32'h0000_0000);
    queue_traffic(PHASE_BYTES);
    wait_drained();

    idle_mode = IDLE_TX_HEAVY;
    apb_write(START_BYTE_ADDR, 32'h0000_00FF);
    queue_traffic(PHASE_BYTES);
    wait_drained();

    idle_mode = IDLE_OFF;
    apb_write(START_BYTE_ADDR, $urandom_range(1, 254));
    hold_req++;  // long receiver stall while bytes keep coming
    queue_traffic(PHASE_BYTES);
    wait_drained();

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: packet_framer_sum_resync.f
hdl/pfsr_pkg.sv
hdl/pfsr_ram.sv
hdl/pfsr_dp.sv
hdl/pfsr_ctrl.sv
hdl/packet_framer_sum_resync.sv
tb/sv/tb_packet_framer_sum_resync.sv
